### sv/eabv_pkg.sv
// ----------------------------------------------------------------------------
// eabv_pkg: shared types and constants for the Euler-angle basis vectors
// Angle and result item types, fixed-point constants, Horner divisor tables
// and the rounding and saturation helpers used by the product pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package eabv_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int FX_W       = 16;             // output component width
  localparam int QUAD_OFS_W = ANGLE_BITS - 2; // offset bits inside a quadrant

  // Quarter-wave sine and cosine work in unsigned Q30
  localparam int Q_FRAC = 30;
  localparam int XW     = 31;                 // x and t, up to about 1.58
  localparam int X2W    = 32;                 // x squared, up to about 2.47
  localparam logic [XW-1:0] Q_ONE       = XW'(1) << Q_FRAC;
  localparam logic [XW-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam int NARROW_SH = Q_FRAC - FRAC_BITS;
  localparam int NW        = FRAC_BITS + 1;   // narrowed magnitude width

  // Horner steps: t = ONE - floor(floor(x2*t / ONE) / k)
  localparam int HSTEPS = 6;
  localparam int unsigned SIN_DIV   [HSTEPS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV   [HSTEPS] = '{132, 90, 56, 30, 12, 2};
  // Reciprocal shifts: 32 + ceil(log2(k)) keeps floor(p*M >> s) exact for p < 2^32
  localparam int unsigned SIN_SHIFT [HSTEPS] = '{40, 39, 39, 38, 37, 35};
  localparam int unsigned COS_SHIFT [HSTEPS] = '{40, 39, 38, 37, 36, 33};
  localparam int RECIP_W = 33;

  localparam int SC_LAT   = 5 + 3 * HSTEPS;   // sine/cosine pipeline depth
  localparam int PROD_LAT = 5;                // product and sum stages
  localparam int BV_LAT   = SC_LAT + PROD_LAT;

  localparam logic signed [FX_W:0] FX_LIM = (FX_W + 1)'(1) <<< FRAC_BITS;

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quad_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] pitch_angle;
    logic [ANGLE_BITS-1:0] yaw_angle;
    logic [ANGLE_BITS-1:0] roll_angle;
  } angles_t;

  typedef struct packed {
    logic signed [FX_W-1:0] forward_x;
    logic signed [FX_W-1:0] forward_y;
    logic signed [FX_W-1:0] forward_z;
    logic signed [FX_W-1:0] right_x;
    logic signed [FX_W-1:0] right_y;
    logic signed [FX_W-1:0] right_z;
    logic signed [FX_W-1:0] up_x;
    logic signed [FX_W-1:0] up_y;
    logic signed [FX_W-1:0] up_z;
  } basis_t;

  typedef struct packed {
    logic signed [FX_W-1:0] sin;
    logic signed [FX_W-1:0] cos;
  } sincos_t;

  // Round a full product back to FRAC_BITS, half away from zero
  function automatic logic signed [FX_W-1:0] fx_round(input logic signed [2*FX_W-1:0] p);
    logic [2*FX_W-1:0] mag;
    logic [2*FX_W-1:0] rnd;
    mag = p[2*FX_W-1] ? (2*FX_W)'(-p) : (2*FX_W)'(p);
    rnd = (mag + ((2*FX_W)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return p[2*FX_W-1] ? -FX_W'(rnd) : FX_W'(rnd);
  endfunction

  // Clamp a component sum to [-1.0, +1.0]
  function automatic logic signed [FX_W-1:0] fx_sat(input logic signed [FX_W:0] v);
    logic signed [FX_W-1:0] res;
    res = v[FX_W-1:0];
    if (v > FX_LIM) begin
      res = FX_W'(FX_LIM);
    end else if (v < -FX_LIM) begin
      res = FX_W'(-FX_LIM);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/eabv_sincos.sv
// ----------------------------------------------------------------------------
// eabv_sincos: pipelined sine and cosine of a binary angle
// Quadrant split, offset scaled to radians, six-step Horner chains for the
// quarter-wave sine and cosine, narrowing to Q2.14 and quadrant mapping.
// ----------------------------------------------------------------------------
`default_nettype none

module eabv_sincos (
  input  logic                            clk,
  input  logic [eabv_pkg::ANGLE_BITS-1:0] angle,
  output eabv_pkg::sincos_t               sc
);
  import eabv_pkg::*;

  // Stage 1: quadrant and offset in radians
  logic [QUAD_OFS_W+XW-1:0] xprod;
  logic [XW-1:0]            x0;
  quad_t                    q0;

  assign xprod = (QUAD_OFS_W + XW)'(angle[QUAD_OFS_W-1:0]) * (QUAD_OFS_W + XW)'(HALF_PI_Q30);

  always_ff @(posedge clk) begin
    x0 <= xprod[QUAD_OFS_W +: XW];
    q0 <= quad_t'(angle[ANGLE_BITS-1 -: 2]);
  end

  // Stage 2: x squared
  logic [2*XW-1:0] xsq;
  logic [X2W-1:0]  x2_1;
  logic [XW-1:0]   x1;
  quad_t           q1;

  assign xsq = (2 * XW)'(x0) * (2 * XW)'(x0);

  always_ff @(posedge clk) begin
    x2_1 <= xsq[Q_FRAC +: X2W];
    x1   <= x0;
    q1   <= q0;
  end

  // Horner chains, three stages a step: multiply, reciprocal, subtract
  logic [X2W-1:0] hx2 [HSTEPS];
  logic [XW-1:0]  hx  [HSTEPS+1];
  quad_t          hq  [HSTEPS+1];
  logic [XW-1:0]  hts [HSTEPS+1];
  logic [XW-1:0]  htc [HSTEPS+1];

  assign hx2[0] = x2_1;
  assign hx[0]  = x1;
  assign hq[0]  = q1;
  assign hts[0] = Q_ONE;
  assign htc[0] = Q_ONE;

  for (genvar i = 0; i < HSTEPS; i++) begin : g_step
    localparam int unsigned SSH = SIN_SHIFT[i];
    localparam int unsigned CSH = COS_SHIFT[i];
    localparam logic [RECIP_W-1:0] SREC = RECIP_W'(((65'd1 << SSH) + 65'(SIN_DIV[i]) - 65'd1)
                                                   / 65'(SIN_DIV[i]));
    localparam logic [RECIP_W-1:0] CREC = RECIP_W'(((65'd1 << CSH) + 65'(COS_DIV[i]) - 65'd1)
                                                   / 65'(COS_DIV[i]));

    logic [X2W+XW-1:0]      ms, mc;
    logic [X2W+RECIP_W-1:0] rs, rc;
    logic [X2W-1:0]         pas, pac;
    logic [XW-1:0]          qbs, qbc, tcs, tcc;
    logic [XW-1:0]          ax, bx, cx;
    quad_t                  aq, bq, cq;

    assign ms = (X2W + XW)'(hx2[i]) * (X2W + XW)'(hts[i]);
    assign mc = (X2W + XW)'(hx2[i]) * (X2W + XW)'(htc[i]);
    assign rs = (X2W + RECIP_W)'(pas) * (X2W + RECIP_W)'(SREC);
    assign rc = (X2W + RECIP_W)'(pac) * (X2W + RECIP_W)'(CREC);

    always_ff @(posedge clk) begin
      pas <= ms[Q_FRAC +: X2W];
      pac <= mc[Q_FRAC +: X2W];
      ax  <= hx[i];
      aq  <= hq[i];
      qbs <= XW'(rs >> SSH);
      qbc <= XW'(rc >> CSH);
      bx  <= ax;
      bq  <= aq;
      // a subtrahend above one drives the term to zero
      tcs <= (qbs > Q_ONE) ? '0 : Q_ONE - qbs;
      tcc <= (qbc > Q_ONE) ? '0 : Q_ONE - qbc;
      cx  <= bx;
      cq  <= bq;
    end

    assign hts[i+1] = tcs;
    assign htc[i+1] = tcc;
    assign hx[i+1]  = cx;
    assign hq[i+1]  = cq;

    if (i + 1 < HSTEPS) begin : g_x2
      logic [X2W-1:0] ax2, bx2, cx2;
      always_ff @(posedge clk) begin
        ax2 <= hx2[i];
        bx2 <= ax2;
        cx2 <= bx2;
      end
      assign hx2[i+1] = cx2;
    end
  end

  // Final sine product
  logic [2*XW-1:0] sprod;
  logic [XW-1:0]   sv, cv;
  quad_t           fq;

  assign sprod = (2 * XW)'(hx[HSTEPS]) * (2 * XW)'(hts[HSTEPS]);

  always_ff @(posedge clk) begin
    sv <= sprod[Q_FRAC +: XW];
    cv <= htc[HSTEPS];
    fq <= hq[HSTEPS];
  end

  // Clamp to one and narrow to FRAC_BITS, rounding half up
  logic [XW-1:0] svc, cvc, svr, cvr;
  logic [NW-1:0] sn, cn;
  quad_t         nq;

  always_comb begin
    svc = (sv > Q_ONE) ? Q_ONE : sv;
    cvc = (cv > Q_ONE) ? Q_ONE : cv;
    svr = svc + (XW'(1) << (NARROW_SH - 1));
    cvr = cvc + (XW'(1) << (NARROW_SH - 1));
  end

  always_ff @(posedge clk) begin
    sn <= NW'(svr >> NARROW_SH);
    cn <= NW'(cvr >> NARROW_SH);
    nq <= fq;
  end

  // Quadrant mapping
  logic signed [FX_W-1:0] s_pos, c_pos;
  sincos_t                sc_next;

  assign s_pos = $signed({{(FX_W - NW){1'b0}}, sn});
  assign c_pos = $signed({{(FX_W - NW){1'b0}}, cn});

  always_comb begin
    case (nq)
      QUAD_FIRST: begin
        sc_next.sin = s_pos;
        sc_next.cos = c_pos;
      end
      QUAD_SECOND: begin
        sc_next.sin = c_pos;
        sc_next.cos = -s_pos;
      end
      QUAD_THIRD: begin
        sc_next.sin = -s_pos;
        sc_next.cos = -c_pos;
      end
      default: begin
        sc_next.sin = -c_pos;
        sc_next.cos = s_pos;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    sc <= sc_next;
  end

endmodule

`default_nettype wire

### sv/euler_angles_to_basis_vectors.sv
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors: forward, right and up vectors from angles
// Throughput: one item per cycle; sine/cosine take 23 stages, products 5.
// busy is high only while rst is high; the result is shown for one cycle.
// Synchronous reset clears the valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_angles_to_basis_vectors (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  eabv_pkg::angles_t angles,
  output logic              busy,
  output logic              done,
  output eabv_pkg::basis_t  basis
);
  import eabv_pkg::*;

  localparam int PW = 2 * FX_W;

  logic              accept;
  logic [BV_LAT-1:0] vpipe;

  assign busy   = rst;
  assign accept = start & ~busy;

  // Valid bits travel alongside the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[BV_LAT-2:0], accept};
    end
  end

  assign done = vpipe[BV_LAT-1];

  sincos_t scp, scy, scr;

  eabv_sincos u_pitch (.clk(clk), .angle(angles.pitch_angle), .sc(scp));
  eabv_sincos u_yaw   (.clk(clk), .angle(angles.yaw_angle),   .sc(scy));
  eabv_sincos u_roll  (.clk(clk), .angle(angles.roll_angle),  .sc(scr));

  // P1: first-level products
  logic signed [PW-1:0]   m_cpcy, m_cpsy, m_srsp, m_crsp, m_crsy;
  logic signed [PW-1:0]   m_crcy, m_srsy, m_srcy, m_srcp, m_crcp;
  logic signed [FX_W-1:0] d1_sp, d1_sy, d1_cy;

  always_ff @(posedge clk) begin
    m_cpcy <= PW'(scp.cos) * PW'(scy.cos);
    m_cpsy <= PW'(scp.cos) * PW'(scy.sin);
    m_srsp <= PW'(scr.sin) * PW'(scp.sin);
    m_crsp <= PW'(scr.cos) * PW'(scp.sin);
    m_crsy <= PW'(scr.cos) * PW'(scy.sin);
    m_crcy <= PW'(scr.cos) * PW'(scy.cos);
    m_srsy <= PW'(scr.sin) * PW'(scy.sin);
    m_srcy <= PW'(scr.sin) * PW'(scy.cos);
    m_srcp <= PW'(scr.sin) * PW'(scp.cos);
    m_crcp <= PW'(scr.cos) * PW'(scp.cos);
    d1_sp  <= scp.sin;
    d1_sy  <= scy.sin;
    d1_cy  <= scy.cos;
  end

  // P2: round first-level products
  logic signed [FX_W-1:0] r_cpcy, r_cpsy, r_srsp, r_crsp, r_crsy;
  logic signed [FX_W-1:0] r_crcy, r_srsy, r_srcy, r_srcp, r_crcp;
  logic signed [FX_W-1:0] d2_sp, d2_sy, d2_cy;

  always_ff @(posedge clk) begin
    r_cpcy <= fx_round(m_cpcy);
    r_cpsy <= fx_round(m_cpsy);
    r_srsp <= fx_round(m_srsp);
    r_crsp <= fx_round(m_crsp);
    r_crsy <= fx_round(m_crsy);
    r_crcy <= fx_round(m_crcy);
    r_srsy <= fx_round(m_srsy);
    r_srcy <= fx_round(m_srcy);
    r_srcp <= fx_round(m_srcp);
    r_crcp <= fx_round(m_crcp);
    d2_sp  <= d1_sp;
    d2_sy  <= d1_sy;
    d2_cy  <= d1_cy;
  end

  // P3: triple products on the rounded roll-pitch terms
  logic signed [PW-1:0]   n_srspcy, n_srspsy, n_crspcy, n_crspsy;
  logic signed [FX_W-1:0] d3_cpcy, d3_cpsy, d3_crsy, d3_crcy, d3_srsy;
  logic signed [FX_W-1:0] d3_srcy, d3_srcp, d3_crcp, d3_sp;

  always_ff @(posedge clk) begin
    n_srspcy <= PW'(r_srsp) * PW'(d2_cy);
    n_srspsy <= PW'(r_srsp) * PW'(d2_sy);
    n_crspcy <= PW'(r_crsp) * PW'(d2_cy);
    n_crspsy <= PW'(r_crsp) * PW'(d2_sy);
    d3_cpcy  <= r_cpcy;
    d3_cpsy  <= r_cpsy;
    d3_crsy  <= r_crsy;
    d3_crcy  <= r_crcy;
    d3_srsy  <= r_srsy;
    d3_srcy  <= r_srcy;
    d3_srcp  <= r_srcp;
    d3_crcp  <= r_crcp;
    d3_sp    <= d2_sp;
  end

  // P4: round triple products
  logic signed [FX_W-1:0] t_srspcy, t_srspsy, t_crspcy, t_crspsy;
  logic signed [FX_W-1:0] d4_cpcy, d4_cpsy, d4_crsy, d4_crcy, d4_srsy;
  logic signed [FX_W-1:0] d4_srcy, d4_srcp, d4_crcp, d4_sp;

  always_ff @(posedge clk) begin
    t_srspcy <= fx_round(n_srspcy);
    t_srspsy <= fx_round(n_srspsy);
    t_crspcy <= fx_round(n_crspcy);
    t_crspsy <= fx_round(n_crspsy);
    d4_cpcy  <= d3_cpcy;
    d4_cpsy  <= d3_cpsy;
    d4_crsy  <= d3_crsy;
    d4_crcy  <= d3_crcy;
    d4_srsy  <= d3_srsy;
    d4_srcy  <= d3_srcy;
    d4_srcp  <= d3_srcp;
    d4_crcp  <= d3_crcp;
    d4_sp    <= d3_sp;
  end

  // P5: sums, saturation and the result register
  basis_t basis_next;

  always_comb begin
    basis_next.forward_x = fx_sat((FX_W + 1)'(d4_cpcy));
    basis_next.forward_y = fx_sat((FX_W + 1)'(d4_cpsy));
    basis_next.forward_z = fx_sat(-(FX_W + 1)'(d4_sp));
    basis_next.right_x   = fx_sat((FX_W + 1)'(d4_crsy) - (FX_W + 1)'(t_srspcy));
    basis_next.right_y   = fx_sat(-(FX_W + 1)'(t_srspsy) - (FX_W + 1)'(d4_crcy));
    basis_next.right_z   = fx_sat(-(FX_W + 1)'(d4_srcp));
    basis_next.up_x      = fx_sat((FX_W + 1)'(t_crspcy) + (FX_W + 1)'(d4_srsy));
    basis_next.up_y      = fx_sat((FX_W + 1)'(t_crspsy) - (FX_W + 1)'(d4_srcy));
    basis_next.up_z      = fx_sat((FX_W + 1)'(d4_crcp));
  end

  always_ff @(posedge clk) begin
    basis <= basis_next;
  end

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##BV_LAT done)
    else $error("accepted item did not complete at the pipeline depth");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, BV_LAT))
    else $error("done without a matching accepted item");

  a_forward_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (basis.forward_x <= FX_LIM && basis.forward_x >= -FX_LIM &&
              basis.forward_y <= FX_LIM && basis.forward_y >= -FX_LIM &&
              basis.forward_z <= FX_LIM && basis.forward_z >= -FX_LIM))
    else $error("forward component outside unit range");

  a_up_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (basis.up_x <= FX_LIM && basis.up_x >= -FX_LIM &&
              basis.up_z <= FX_LIM && basis.up_z >= -FX_LIM &&
              basis.right_z <= FX_LIM && basis.right_z >= -FX_LIM))
    else $error("up or right component outside unit range");
`endif

endmodule

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for euler_angles_to_basis_vectors
// Drives pitch/yaw/roll items through the start/busy handshake and checks
// each done strobe against a bit-exact fixed-point predictor or a typed
// table row. A directed table covers quadrant edges and wrap; random items
// follow under light, heavy and no input gaps.
// ----------------------------------------------------------------------------

module tb_top;

  import eabv_pkg::*;

  localparam int PIPE_DEPTH       = BV_LAT;
  localparam int RANDOM_PER_PHASE = 434;
  localparam int CYCLE_LIMIT      = 200000;
  localparam int NUM_DIRECTED     = 24;

  localparam logic [63:0] Q30_UNIT             = 64'd1 << 30;
  localparam logic [63:0] QUARTER_TURN_RAD_Q30 = 64'd1686629713;
  localparam longint      FX_UNIT              = 64'sd16384;

  localparam logic [15:0] UNIT_POS = 16'h4000;
  localparam logic [15:0] UNIT_NEG = 16'hC000;
  localparam logic [15:0] ZERO_FX  = 16'h0000;

  typedef struct packed {
    logic    typed;
    angles_t ang;
    basis_t  want;
  } stim_row_t;

  logic    clk = 1'b0;
  logic    rst;
  logic    start;
  angles_t angles;
  logic    busy;
  logic    done;
  basis_t  basis;

  basis_t  expected_basis [$];
  basis_t  want_basis;
  int      mismatches      = 0;
  int      results_checked = 0;
  int      items_sent      = 0;
  int      cycle_count     = 0;

  // Rows with typed = 1 carry the vectors read straight off the axes.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b1, {16'h0000, 16'h0000, 16'h0000},
      {UNIT_POS, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_NEG, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_POS}},
    '{1'b1, {16'h4000, 16'h0000, 16'h0000},
      {ZERO_FX, ZERO_FX, UNIT_NEG, ZERO_FX, UNIT_NEG, ZERO_FX, UNIT_POS, ZERO_FX, ZERO_FX}},
    '{1'b1, {16'h8000, 16'h0000, 16'h0000},
      {UNIT_NEG, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_NEG, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_NEG}},
    '{1'b1, {16'h0000, 16'h4000, 16'h0000},
      {ZERO_FX, UNIT_POS, ZERO_FX, UNIT_POS, ZERO_FX, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_POS}},
    '{1'b1, {16'h0000, 16'h0000, 16'h4000},
      {UNIT_POS, ZERO_FX, ZERO_FX, ZERO_FX, ZERO_FX, UNIT_NEG, ZERO_FX, UNIT_NEG, ZERO_FX}},
    '{1'b0, {16'hC000, 16'h0000, 16'h0000}, '0},
    '{1'b0, {16'h0000, 16'h8000, 16'h0000}, '0},
    '{1'b0, {16'h0000, 16'hC000, 16'h0000}, '0},
    '{1'b0, {16'h0000, 16'h0000, 16'h8000}, '0},
    '{1'b0, {16'h0000, 16'h0000, 16'hC000}, '0},
    '{1'b0, {16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
    '{1'b0, {16'h0001, 16'h0001, 16'h0001}, '0},
    '{1'b0, {16'h3FFF, 16'h3FFF, 16'h3FFF}, '0},
    '{1'b0, {16'h7FFF, 16'hBFFF, 16'hFFFF}, '0},
    '{1'b0, {16'h4001, 16'h8001, 16'hC001}, '0},
    '{1'b0, {16'h2000, 16'h2000, 16'h2000}, '0},
    '{1'b0, {16'hE000, 16'h6000, 16'hA000}, '0},
    '{1'b0, {16'hAAAA, 16'h5555, 16'hAAAA}, '0},
    '{1'b0, {16'h5555, 16'hAAAA, 16'h5555}, '0},
    '{1'b0, {16'h1234, 16'h9ABC, 16'hF00F}, '0},
    '{1'b0, {16'hC000, 16'hC000, 16'hC000}, '0},
    '{1'b0, {16'h4000, 16'h4000, 16'h4000}, '0},
    '{1'b0, {16'hFFFF, 16'h0000, 16'h8000}, '0},
    '{1'b0, {16'h3000, 16'hD000, 16'h1000}, '0}
  };

  euler_angles_to_basis_vectors dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .angles (angles),
    .busy   (busy),
    .done   (done),
    .basis  (basis)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned series_divisor(bit sine, int step);
    int unsigned k;
    case (step)
      0:       k = sine ? 156 : 132;
      1:       k = sine ? 110 : 90;
      2:       k = sine ? 72  : 56;
      3:       k = sine ? 42  : 30;
      4:       k = sine ? 20  : 12;
      default: k = sine ? 6   : 2;
    endcase
    return k;
  endfunction

  // Horner chain of the quarter-wave sine or cosine series, unsigned Q30
  function automatic logic [63:0] quarter_series(logic [63:0] x2, bit sine);
    logic [63:0] t;
    logic [63:0] sub;
    t = Q30_UNIT;
    for (int i = 0; i < 6; i++) begin
      sub = ((x2 * t) >> 30) / 64'(series_divisor(sine, i));
      t = (sub > Q30_UNIT) ? 64'd0 : Q30_UNIT - sub;
    end
    return t;
  endfunction

  function automatic void angle_sincos(input logic [15:0] ang,
                                       output longint s, output longint c);
    quad_t       quad;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sv;
    logic [63:0] cv;
    longint      s_q;
    longint      c_q;
    quad = quad_t'(ang[15:14]);
    x  = (64'(ang[13:0]) * QUARTER_TURN_RAD_Q30) >> 14;
    x2 = (x * x) >> 30;
    sv = (x * quarter_series(x2, 1'b1)) >> 30;
    cv = quarter_series(x2, 1'b0);
    if (sv > Q30_UNIT) sv = Q30_UNIT;
    if (cv > Q30_UNIT) cv = Q30_UNIT;
    // both are non-negative, so rounding half up is half away from zero
    s_q = longint'((sv + 64'd32768) >> 16);
    c_q = longint'((cv + 64'd32768) >> 16);
    case (quad)
      QUAD_FIRST:  begin s = s_q;  c = c_q;  end
      QUAD_SECOND: begin s = c_q;  c = -s_q; end
      QUAD_THIRD:  begin s = -s_q; c = -c_q; end
      default:     begin s = -c_q; c = s_q;  end
    endcase
  endfunction

  function automatic longint round_mul(longint a, longint b);
    longint p;
    longint m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + 64'sd8192) >> 14;
    return (p < 0) ? -m : m;
  endfunction

  function automatic logic [15:0] clamp_unit(longint v);
    if (v > FX_UNIT) v = FX_UNIT;
    if (v < -FX_UNIT) v = -FX_UNIT;
    return 16'(v);
  endfunction

  function automatic basis_t predict_basis(angles_t a);
    longint sp, cp, sy, cy, sr, cr, srsp, crsp;
    basis_t b;
    angle_sincos(a.pitch_angle, sp, cp);
    angle_sincos(a.yaw_angle, sy, cy);
    angle_sincos(a.roll_angle, sr, cr);
    srsp = round_mul(sr, sp);
    crsp = round_mul(cr, sp);
    b.forward_x = clamp_unit(round_mul(cp, cy));
    b.forward_y = clamp_unit(round_mul(cp, sy));
    b.forward_z = clamp_unit(-sp);
    b.right_x   = clamp_unit(-round_mul(srsp, cy) + round_mul(cr, sy));
    b.right_y   = clamp_unit(-round_mul(srsp, sy) - round_mul(cr, cy));
    b.right_z   = clamp_unit(-round_mul(sr, cp));
    b.up_x      = clamp_unit(round_mul(crsp, cy) + round_mul(sr, sy));
    b.up_y      = clamp_unit(round_mul(crsp, sy) - round_mul(sr, cy));
    b.up_z      = clamp_unit(round_mul(cr, cp));
    return b;
  endfunction

  // ----------------------------------------------------------------- stimulus
  // Mostly uniform angles; the rest sit at quadrant edges or on the axes.
  function automatic logic [15:0] random_angle();
    int unsigned pick;
    logic [15:0] a;
    pick = $urandom_range(99);
    if (pick < 60) begin
      a = 16'($urandom);
    end else if (pick < 85) begin
      a[15:14] = 2'($urandom);
      a[13:0]  = $urandom_range(1) ? 14'($urandom_range(15))
                                   : 14'(16383 - $urandom_range(15));
    end else begin
      case ($urandom_range(7))
        0:       a = 16'h0000;
        1:       a = 16'h3FFF;
        2:       a = 16'h4000;
        3:       a = 16'h7FFF;
        4:       a = 16'h8000;
        5:       a = 16'hBFFF;
        6:       a = 16'hC000;
        default: a = 16'hFFFF;
      endcase
    end
    return a;
  endfunction

  task automatic send_item(input angles_t a, input basis_t want, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start  <= 1'b1;
    angles <= a;
    do @(posedge clk); while (busy);
    expected_basis.push_back(want);
    items_sent++;
  endtask

  // Hold off the input until every outstanding result has come back.
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (expected_basis.size() != 0) @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct);
    angles_t a;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      a.pitch_angle = random_angle();
      a.yaw_angle   = random_angle();
      a.roll_angle  = random_angle();
      send_item(a, predict_basis(a), idle_pct);
    end
  endtask

  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    angles = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_item(directed_rows[i].ang,
                directed_rows[i].typed ? directed_rows[i].want
                                       : predict_basis(directed_rows[i].ang),
                13);
    end
    drain_results();

    run_random_phase(13);
    drain_results();
    run_random_phase(54);
    drain_results();
    run_random_phase(0);
    drain_results();

    // catch any stray strobe after the last result
    repeat (PIPE_DEPTH + 8) @(posedge clk);

    $display("Covered %0d items: %0d from the directed table, the rest random under",
             items_sent, NUM_DIRECTED);
    $display("light, heavy and no input gaps; %0d results compared, %0d mismatches.",
             results_checked, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // ------------------------------------------------------------------ checker
  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if ($isunknown(done)) begin
        $error("done: expected 0 or 1, got %b", done);
        mismatches++;
      end else if (done) begin
        if (expected_basis.size() == 0) begin
          $error("result with no item outstanding: %h", basis);
          mismatches++;
        end else begin
          want_basis = expected_basis.pop_front();
          check_field("forward_x", want_basis.forward_x, basis.forward_x);
          check_field("forward_y", want_basis.forward_y, basis.forward_y);
          check_field("forward_z", want_basis.forward_z, basis.forward_z);
          check_field("right_x", want_basis.right_x, basis.right_x);
          check_field("right_y", want_basis.right_y, basis.right_y);
          check_field("right_z", want_basis.right_z, basis.right_z);
          check_field("up_x", want_basis.up_x, basis.up_x);
          check_field("up_y", want_basis.up_y, basis.up_y);
          check_field("up_z", want_basis.up_z, basis.up_z);
          results_checked++;
        end
      end
    end
  end

endmodule
